// ----- src/isiq_pkg.sv -----
// ----------------------------------------------------------------------------
// isiq_pkg
// Shared types and constants for the interval set insert/query block.
// ----------------------------------------------------------------------------
`default_nettype none

package isiq_pkg;

  localparam int unsigned VAL_W             = 32;
  localparam int unsigned CNT_OUT_W         = 7;
  localparam int unsigned MAX_INTERVALS_DEF = 64;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // What the token does in the cell it has reached.
  typedef enum logic [1:0] {
    MODE_SEARCH,
    MODE_SHR,
    MODE_SHL
  } mode_t;

  // Token handed from one cell to its right neighbor. For a right shift it
  // carries the interval displaced from the left cell.
  typedef struct packed {
    logic             tok;
    mode_t            mode;
    logic [VAL_W-1:0] s;
    logic [VAL_W-1:0] e;
  } link_t;

  // Completion report of the cell that ends the operation.
  typedef struct packed {
    logic fin;
    logic member;
    logic drop;
    logic inc;
    logic dec;
  } fin_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- src/isiq_if.sv -----
// ----------------------------------------------------------------------------
// isiq_in_if / isiq_out_if
// Valid/ready channels for items and results of the interval set block.
// ----------------------------------------------------------------------------
`default_nettype none

interface isiq_in_if import isiq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [VAL_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

interface isiq_out_if import isiq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 was_member;
  logic [CNT_OUT_W-1:0] interval_count;
  logic                 full_drop;

  modport source (output valid, output was_member, output interval_count,
                  output full_drop, input ready);
  modport sink (input valid, input was_member, input interval_count,
                input full_drop, output ready);
endinterface

`default_nettype wire

// ----- src/isiq_cell.sv -----
// ----------------------------------------------------------------------------
// isiq_cell
// One table slot: holds one interval and acts on the token when it arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module isiq_cell import isiq_pkg::*; #(
  parameter int unsigned CNT_W = 7,
  parameter int unsigned IDX   = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [VAL_W-1:0] v,
  input  wire logic             add,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic             full,
  input  wire link_t            lk_in,
  input  wire logic [VAL_W-1:0] nb_s,
  input  wire logic [VAL_W-1:0] nb_e,
  output logic      [VAL_W-1:0] start_o,
  output logic      [VAL_W-1:0] end_o,
  output link_t                 lk_out,
  output fin_t                  fin_o
);

  localparam logic [CNT_W:0] IDX_C  = (CNT_W+1)'(IDX);
  localparam logic [CNT_W:0] IDX1_C = (CNT_W+1)'(IDX + 1);

  logic [VAL_W-1:0] start_r, start_nxt;
  logic [VAL_W-1:0] end_r, end_nxt;
  link_t            lk_r;

  logic           valid, nb_valid;
  logic [VAL_W:0] v33, s33, e33, nb33, vp1, ep1;
  logic           covered, below, start_adj, end_adj, merge_ok;

  // Slot occupancy follows from the fill count.
  assign valid    = IDX_C < {1'b0, count};
  assign nb_valid = IDX1_C < {1'b0, count};

  // Compares run one bit wider so that neighbors of the range limits work.
  assign v33       = {v[VAL_W-1], v};
  assign s33       = {start_r[VAL_W-1], start_r};
  assign e33       = {end_r[VAL_W-1], end_r};
  assign nb33      = {nb_s[VAL_W-1], nb_s};
  assign vp1       = v33 + (VAL_W+1)'(1);
  assign ep1       = e33 + (VAL_W+1)'(1);
  assign covered   = ($signed(v33) >= $signed(s33)) && ($signed(v33) <= $signed(e33));
  assign below     = $signed(v33) < $signed(s33);
  assign start_adj = vp1 == s33;
  assign end_adj   = v33 == ep1;
  assign merge_ok  = nb_valid && (vp1 == nb33);

  always_comb begin
    start_nxt = start_r;
    end_nxt   = end_r;
    lk_out    = '0;
    fin_o     = '0;
    if (lk_r.tok) begin
      unique case (lk_r.mode)
        MODE_SEARCH: begin
          priority if (!valid) begin
            // First free slot: append here, or end a lookup that found nothing.
            if (add) begin
              start_nxt = v;
              end_nxt   = v;
              fin_o.inc = 1'b1;
            end
            fin_o.fin = 1'b1;
          end else if (covered) begin
            fin_o.fin    = 1'b1;
            fin_o.member = 1'b1;
          end else if (!add) begin
            if (below) begin
              fin_o.fin = 1'b1;
            end else begin
              lk_out.tok  = 1'b1;
              lk_out.mode = MODE_SEARCH;
            end
          end else if (start_adj) begin
            start_nxt = v;
            fin_o.fin = 1'b1;
          end else if (below) begin
            if (full) begin
              fin_o.fin  = 1'b1;
              fin_o.drop = 1'b1;
            end else begin
              // Take the new interval and push the old one to the right.
              start_nxt   = v;
              end_nxt     = v;
              lk_out.tok  = 1'b1;
              lk_out.mode = MODE_SHR;
              lk_out.s    = start_r;
              lk_out.e    = end_r;
            end
          end else if (end_adj) begin
            if (merge_ok) begin
              // Absorb the right neighbor, then close the gap behind it.
              end_nxt     = nb_e;
              lk_out.tok  = 1'b1;
              lk_out.mode = MODE_SHL;
            end else begin
              end_nxt   = v;
              fin_o.fin = 1'b1;
            end
          end else begin
            lk_out.tok  = 1'b1;
            lk_out.mode = MODE_SEARCH;
          end
        end
        MODE_SHR: begin
          start_nxt = lk_r.s;
          end_nxt   = lk_r.e;
          if (!valid) begin
            fin_o.fin = 1'b1;
            fin_o.inc = 1'b1;
          end else begin
            lk_out.tok  = 1'b1;
            lk_out.mode = MODE_SHR;
            lk_out.s    = start_r;
            lk_out.e    = end_r;
          end
        end
        MODE_SHL: begin
          if (nb_valid) begin
            start_nxt   = nb_s;
            end_nxt     = nb_e;
            lk_out.tok  = 1'b1;
            lk_out.mode = MODE_SHL;
          end else begin
            fin_o.fin = 1'b1;
            fin_o.dec = 1'b1;
          end
        end
        default: begin
          fin_o = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    end_r   <= end_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lk_r <= '0;
    end else begin
      lk_r <= lk_in;
    end
  end

  assign start_o = start_r;
  assign end_o   = end_r;

endmodule

`default_nettype wire

// ----- src/isiq_chain.sv -----
// ----------------------------------------------------------------------------
// isiq_chain
// Row of interval cells linked left to right, with the completion reports
// of all cells gathered into one.
// ----------------------------------------------------------------------------
`default_nettype none

module isiq_chain import isiq_pkg::*; #(
  parameter int unsigned N     = MAX_INTERVALS_DEF,
  parameter int unsigned CNT_W = 7
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [VAL_W-1:0] v,
  input  wire logic             add,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic             full,
  input  wire link_t            lk_head,
  output link_t                 lk_tail,
  output fin_t                  fin_o
);

  logic [VAL_W-1:0] st [N];
  logic [VAL_W-1:0] en [N];
  link_t            lk [N+1];
  fin_t             fin_v [N];

  assign lk[0] = lk_head;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [VAL_W-1:0] nb_s, nb_e;

    if (i + 1 < N) begin : g_nb
      assign nb_s = st[i+1];
      assign nb_e = en[i+1];
    end else begin : g_last
      // The last slot never has a right neighbor.
      assign nb_s = '0;
      assign nb_e = '0;
    end

    isiq_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .v       (v),
      .add     (add),
      .count   (count),
      .full    (full),
      .lk_in   (lk[i]),
      .nb_s    (nb_s),
      .nb_e    (nb_e),
      .start_o (st[i]),
      .end_o   (en[i]),
      .lk_out  (lk[i+1]),
      .fin_o   (fin_v[i])
    );
  end

  assign lk_tail = lk[N];

  // At most one cell holds the token, so the reports simply OR together.
  always_comb begin
    fin_o = '0;
    for (int i = 0; i < N; i++) begin
      fin_o = fin_o | fin_v[i];
    end
  end

endmodule

`default_nettype wire

// ----- src/interval_set_insert_query.sv -----
// ----------------------------------------------------------------------------
// interval_set_insert_query
// Sorted set of disjoint inclusive intervals with add and membership query.
// ----------------------------------------------------------------------------
// The set lives in a row of MAX_INTERVALS cells, one interval per cell, kept in
// ascending order from cell 0; a fill count tells which cells are occupied.
// Each accepted transaction sends a token into cell 0 that walks right by one
// cell per clock. The cell that holds it compares the value with its own
// interval (and the start of its right neighbor), and either finishes the
// transaction, extends its interval, or turns the token into a shift wave:
// an insert pushes each following interval one cell to the right, a merge
// pulls each following interval one cell to the left, again one cell per
// clock. A transaction is accepted, the token then visits cells (at most
// MAX_INTERVALS, since search and shift together never pass the first free
// cell), and the result register is loaded once the output register is free;
// a transaction ends sooner when the value lands near the low end of a
// sparsely filled table. The walking token is what sets the rate. A new
// transaction is accepted as soon as the previous one has moved its result
// into the output register, even while that result still waits to be taken.
// Every transaction gives one result: membership before the step, the
// interval count after it (low 7 bits) and a drop flag for an add that
// needed a new interval while the table was full. Table contents are not
// reset; only the fill count is.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_set_insert_query import isiq_pkg::*; #(
  parameter int unsigned MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  isiq_in_if.sink   in_ch,
  isiq_out_if.source out_ch
);

  localparam int unsigned CNT_W = $clog2(MAX_INTERVALS + 1);

  state_t state_r, state_nxt;

  logic [VAL_W-1:0] v_r;
  logic             add_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             res_member_r, res_drop_r;

  logic                 out_valid_r;
  logic                 out_member_r;
  logic [CNT_OUT_W-1:0] out_count_r;
  logic                 out_drop_r;

  logic  in_ready, accept, done_ev, load_out, out_free;
  logic  full;
  link_t lk_head, lk_tail;
  fin_t  fin;
  logic [31:0] cnt_wide;

  assign full     = cnt_r == CNT_W'(MAX_INTERVALS);
  assign accept   = in_ch.valid && in_ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // The operation ends when one cell reports completion or the search token
  // falls off the far end of a completely filled table.
  assign done_ev = (state_r == ST_RUN) && (fin.fin || lk_tail.tok);

  // A fresh search token enters cell 0 on the accepting edge.
  always_comb begin
    lk_head      = '0;
    lk_head.tok  = accept;
    lk_head.mode = MODE_SEARCH;
  end

  isiq_chain #(
    .N     (MAX_INTERVALS),
    .CNT_W (CNT_W)
  ) u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .v       (v_r),
    .add     (add_r),
    .count   (cnt_r),
    .full    (full),
    .lk_head (lk_head),
    .lk_tail (lk_tail),
    .fin_o   (fin)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (done_ev) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State outputs. No transaction is taken while reset is held.
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = rst_n;
      end
      ST_RUN: begin
        in_ready = 1'b0;
      end
      ST_DONE: begin
        load_out = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Fill count moves by one on a completed insert or merge.
  always_comb begin
    cnt_nxt = cnt_r;
    if (done_ev) begin
      if (fin.inc) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end else if (fin.dec) begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  assign cnt_wide = 32'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      v_r   <= in_ch.value;
      add_r <= in_ch.command == CMD_ADD;
    end
    if (done_ev) begin
      res_member_r <= fin.member;
      // Running off the end means every slot was taken.
      res_drop_r   <= fin.drop || (lk_tail.tok && add_r);
    end
    if (load_out) begin
      out_member_r <= res_member_r;
      out_drop_r   <= res_drop_r;
      out_count_r  <= cnt_wide[CNT_OUT_W-1:0];
    end
  end

  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.was_member     = out_member_r;
  assign out_ch.interval_count = out_count_r;
  assign out_ch.full_drop      = out_drop_r;

endmodule

`default_nettype wire

// ----- tb/isiq_checker.sv -----
// ----------------------------------------------------------------------------
// isiq_checker
// Watches both channels of the interval set block, keeps its own copy of the
// interval table, and compares every result with the predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module isiq_checker import isiq_pkg::*; #(
  parameter int unsigned MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire logic                 in_command,
  input  wire logic [VAL_W-1:0]     in_value,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire logic                 out_was_member,
  input  wire logic [CNT_OUT_W-1:0] out_interval_count,
  input  wire logic                 out_full_drop,
  output int                        errors,
  output int                        pending,
  output int                        checked,
  output int                        drops_seen,
  output int                        peak_count
);

  typedef struct packed {
    logic                 member;
    logic [CNT_OUT_W-1:0] count;
    logic                 drop;
  } set_result_t;

  // Shadow copy of the interval table.
  logic signed [VAL_W-1:0] lo_tab [MAX_INTERVALS];
  logic signed [VAL_W-1:0] hi_tab [MAX_INTERVALS];
  int                      n_iv;

  set_result_t owed_results [$];

  task automatic log_mismatch(input string what);
    errors++;
    $display("check: %s", what);
  endtask

  // Opens a single-value interval at pos; returns 0 when the table is full.
  function automatic bit open_slot(input int pos, input logic signed [VAL_W-1:0] v);
    if (n_iv >= MAX_INTERVALS) return 1'b0;
    for (int k = n_iv; k > pos; k--) begin
      lo_tab[k] = lo_tab[k-1];
      hi_tab[k] = hi_tab[k-1];
    end
    lo_tab[pos] = v;
    hi_tab[pos] = v;
    n_iv++;
    return 1'b1;
  endfunction

  // Applies one transaction to the shadow table and returns its result.
  // Neighbor tests run on 64-bit values so nothing wraps at the range limits.
  function automatic set_result_t apply_to_set(input logic cmd,
                                               input logic signed [VAL_W-1:0] v);
    set_result_t r;
    longint      x;
    longint      lo;
    longint      hi;
    bit          done;
    x        = longint'(v);
    r.member = 1'b0;
    r.drop   = 1'b0;
    done     = 1'b0;
    for (int i = 0; i < n_iv; i++)
      if (x >= longint'(lo_tab[i]) && x <= longint'(hi_tab[i])) r.member = 1'b1;
    if (cmd == CMD_ADD) begin
      for (int i = 0; i < n_iv && !done; i++) begin
        lo = longint'(lo_tab[i]);
        hi = longint'(hi_tab[i]);
        if (x >= lo && x <= hi) begin
          done = 1'b1;
        end else if (x == lo - 1) begin
          lo_tab[i] = v;
          done      = 1'b1;
        end else if (x < lo) begin
          r.drop = !open_slot(i, v);
          done   = 1'b1;
        end else if (x == hi + 1) begin
          if (i + 1 < n_iv && x == longint'(lo_tab[i+1]) - 1) begin
            // The value bridges two intervals: join them and close the gap.
            hi_tab[i] = hi_tab[i+1];
            for (int k = i + 1; k + 1 < n_iv; k++) begin
              lo_tab[k] = lo_tab[k+1];
              hi_tab[k] = hi_tab[k+1];
            end
            n_iv--;
          end else begin
            hi_tab[i] = v;
          end
          done = 1'b1;
        end
      end
      if (!done) r.drop = !open_slot(n_iv, v);
    end
    r.count = n_iv[CNT_OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    set_result_t want;
    if (!rst_n) begin
      n_iv = 0;
      owed_results.delete();
    end else begin
      // Results are taken before new items so that an item accepted at this
      // edge can never be matched against a result leaving at the same edge.
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          log_mismatch($sformatf("result with nothing outstanding (count %0d)",
                                 out_interval_count));
        end else begin
          want = owed_results.pop_front();
          if (out_was_member !== want.member)
            log_mismatch($sformatf("result %0d: was_member %b, expected %b",
                                   checked, out_was_member, want.member));
          if (out_interval_count !== want.count)
            log_mismatch($sformatf("result %0d: interval_count %0d, expected %0d",
                                   checked, out_interval_count, want.count));
          if (out_full_drop !== want.drop)
            log_mismatch($sformatf("result %0d: full_drop %b, expected %b",
                                   checked, out_full_drop, want.drop));
        end
        checked++;
      end
      if (in_valid && in_ready) begin
        want = apply_to_set(in_command, $signed(in_value));
        owed_results = {owed_results, want};
        if (want.drop) drops_seen++;
        if (n_iv > peak_count) peak_count = n_iv;
      end
    end
    pending <= owed_results.size();
  end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the interval set insert/query block.
// ----------------------------------------------------------------------------
// A short directed run walks an empty table through every kind of add (append,
// insert in front, start and end extension, merge, already covered) and puts
// values at both ends of the signed 32-bit range. The random part then builds
// value clusters: a run of adds spaced two apart opens many intervals, some
// long enough to fill the table and force dropped inserts, and a second pass
// fills most of the gaps so that intervals extend and merge, also while the
// table is full. Random noise transactions and queries are mixed in. The
// isiq_checker instance predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import isiq_pkg::*;

  localparam int unsigned    N_SLOTS     = MAX_INTERVALS_DEF;
  localparam int             TOTAL_ITEMS = 1125;
  localparam int             PHASE_LEN   = TOTAL_ITEMS / 3;
  localparam int             CYCLE_LIMIT = 800000;
  localparam logic [VAL_W-1:0] VAL_MIN   = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_MAX   = 32'h7FFF_FFFF;

  logic clk = 1'b0;
  logic rst_n;

  int send_idle;
  int recv_idle;
  int sent_cnt;
  int add_cnt;
  int query_cnt;
  int cycle_cnt;

  int errors;
  int pending;
  int checked;
  int drops_seen;
  int peak_count;

  isiq_in_if  in_ch ();
  isiq_out_if out_ch ();

  interval_set_insert_query #(
    .MAX_INTERVALS(N_SLOTS)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // The checker only observes; it reports the mismatch count and how many
  // results are still owed, which the stimulus uses to drain the block.
  isiq_checker #(
    .MAX_INTERVALS(N_SLOTS)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_command        (in_ch.command),
    .in_value          (in_ch.value),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_was_member    (out_ch.was_member),
    .out_interval_count(out_ch.interval_count),
    .out_full_drop     (out_ch.full_drop),
    .errors            (errors),
    .pending           (pending),
    .checked           (checked),
    .drops_seen        (drops_seen),
    .peak_count        (peak_count)
  );

  always #5 clk = ~clk;

  // The receiver stalls at random with the percentage of the current phase.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_cnt, pending);
      $display("tb: errors");
      $finish;
    end
  end

  // Holds the input idle until every expected result has been taken. The
  // first wait lets the checker's count catch up with the last transaction.
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Offers one transaction and waits for the handshake. The idle pattern
  // switches at the phase boundaries, each one preceded by a full drain.
  task automatic send_item(input logic cmd, input logic [VAL_W-1:0] val);
    if (sent_cnt == PHASE_LEN) begin
      drain_block();
      send_idle =  72;
      recv_idle <= 26;
    end else if (sent_cnt == 2 * PHASE_LEN) begin
      drain_block();
      send_idle =  0;
      recv_idle <= 0;
    end
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.value   <= val;
    do @(posedge clk); while (!in_ch.ready);
    sent_cnt++;
    if (cmd == CMD_ADD) add_cnt++;
    else query_cnt++;
  endtask

  // Adds base + offset for every offset in the list, in shuffled order. Noise
  // transactions over the whole range and queries into the cluster's window
  // are mixed in between.
  task automatic send_shuffled(input logic [VAL_W-1:0] base, input int span,
                               input int offs [$]);
    int pick;
    int tmp;
    int dice;
    for (int j = offs.size() - 1; j > 0; j--) begin
      pick       = $urandom_range(0, j);
      tmp        = offs[j];
      offs[j]    = offs[pick];
      offs[pick] = tmp;
    end
    foreach (offs[j]) begin
      dice = $urandom_range(0, 99);
      if (dice < 10)
        send_item(logic'($urandom_range(0, 1)), $urandom());
      else if (dice < 22)
        send_item(CMD_QUERY, base + $urandom_range(0, 2 * span) - 1);
      send_item(CMD_ADD, base + offs[j]);
    end
  endtask

  // One cluster: span values two apart open separate intervals, then most of
  // the gaps between them are filled, which extends and merges them. A few
  // gaps stay open so that the interval count creeps up over the run.
  task automatic run_cluster(input int span);
    logic [VAL_W-1:0] base;
    int               offs [$];
    case ($urandom_range(0, 4))
      0:       base = VAL_MIN + $urandom_range(0, 1);
      1:       base = VAL_MAX - 2 * (span - 1) - $urandom_range(0, 1);
      2:       base = $urandom_range(0, 4000) - 2000;
      default: base = $urandom();
    endcase
    for (int k = 0; k < span; k++) offs = {offs, 2 * k};
    send_shuffled(base, span, offs);
    offs.delete();
    for (int k = 0; k + 1 < span; k++)
      if ($urandom_range(0, 9) != 0) offs = {offs, 2 * k + 1};
    send_shuffled(base, span, offs);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.command  = CMD_ADD;
    in_ch.value    = '0;
    send_idle      = 26;
    recv_idle      = 72;
    sent_cnt       = 0;
    add_cnt        = 0;
    query_cnt      = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, starting from the empty table.
    send_item(CMD_QUERY, 32'd0);            // empty table
    send_item(CMD_ADD,   32'd0);            // append to an empty table
    send_item(CMD_ADD,   32'd0);            // already covered
    send_item(CMD_ADD,   32'hFFFF_FFFF);    // -1 extends the start
    send_item(CMD_ADD,   32'd1);            // extends the end
    send_item(CMD_ADD,   VAL_MIN);          // insert in front, lowest value
    send_item(CMD_ADD,   VAL_MAX);          // append, highest value
    send_item(CMD_ADD,   VAL_MAX - 1);      // start extension below the top
    send_item(CMD_ADD,   VAL_MIN + 1);      // end extension above the bottom
    send_item(CMD_QUERY, VAL_MIN);
    send_item(CMD_QUERY, VAL_MAX);
    send_item(CMD_ADD,   32'd3);            // insert in the middle
    send_item(CMD_ADD,   32'd2);            // bridges [-1,1] and [3,3]
    send_item(CMD_QUERY, 32'd2);
    send_item(CMD_QUERY, 32'd4);
    send_item(CMD_ADD,   32'd6);
    send_item(CMD_ADD,   32'd8);
    send_item(CMD_ADD,   32'd7);            // merge of two single values
    send_item(CMD_ADD,   32'd5);            // start extension of [6,8]
    send_item(CMD_ADD,   32'd4);            // merge into one interval [-1,8]
    send_item(CMD_QUERY, 32'hFFFF_FFFE);    // just below the start of [-1,8]
    send_item(CMD_QUERY, VAL_MAX - 2);      // just below the top interval
    send_item(CMD_QUERY, 32'hAAAA_AAAA);
    send_item(CMD_ADD,   32'h5555_5555);
    send_item(CMD_ADD,   32'hAAAA_AAAA);

    // A cluster longer than the table forces dropped inserts right away, and
    // its gap pass then merges while the table is full.
    run_cluster(N_SLOTS + 8);
    while (sent_cnt < TOTAL_ITEMS) begin
      if ($urandom_range(0, 7) == 0) run_cluster($urandom_range(41, 70));
      else run_cluster($urandom_range(2, 40));
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // Any stray result would show up within one more pass of the token.
    repeat (N_SLOTS + 8) @(posedge clk);

    $display("summary: %0d transactions sent (%0d adds, %0d queries), %0d results checked",
             sent_cnt, add_cnt, query_cnt, checked);
    $display("summary: %0d inserts dropped on a full table, peak of %0d intervals",
             drops_seen, peak_count);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("mismatches: %0d", errors);
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
